>>> hdl/lrd_pkg.sv
`timescale 1ns / 1ps

package lrd_pkg;

  localparam int LANE_COUNT   = 4;
  localparam int LANE_BITS    = 32;
  localparam int BLOCK_BYTES  = 16;
  localparam int BLOCK_BITS   = BLOCK_BYTES * 8;
  localparam int DIGEST_BYTES = 16;
  localparam int DIGEST_BITS  = DIGEST_BYTES * 8;
  localparam int TABLE_SIZE   = 32;
  localparam int ROT_MOD      = 24;
  localparam int ROT_BASE     = 8;

  typedef logic [LANE_COUNT-1:0][LANE_BITS-1:0] lane_set_t;
  typedef logic [4:0] rot_table_t [TABLE_SIZE];

  localparam logic [LANE_BITS-1:0] ROUND_TABLE [TABLE_SIZE] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19,
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA
  };

  // Rotate amounts, folded from the round constants at elaboration.
  function automatic rot_table_t build_rot_table();
    rot_table_t t;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      t[i] = 5'((ROUND_TABLE[i] % ROT_MOD) + ROT_BASE);
    end
    return t;
  endfunction

  localparam rot_table_t ROT_TABLE = build_rot_table();

  // One lane round: table pick, rotate left, mix in the block word, add.
  function automatic logic [LANE_BITS-1:0] lane_round(input logic [LANE_BITS-1:0] v,
                                                      input logic [LANE_BITS-1:0] blk);
    logic [2*LANE_BITS-1:0] wide;
    wide = {v, v} << ROT_TABLE[v[4:0]];
    return (wide[2*LANE_BITS-1:LANE_BITS] ^ blk) + ROUND_TABLE[v[4:0]];
  endfunction

endpackage

>>> hdl/lrd_if.sv
`timescale 1ns / 1ps

interface lrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface lrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic       digest_last;

  modport source (output valid, digest_byte, digest_last, input ready);
  modport sink   (input valid, digest_byte, digest_last, output ready);
endinterface

>>> hdl/lut_round_digest.sv
`timescale 1ns / 1ps

// Byte-stream digest with four 32-bit lanes and table-driven rounds.
// msg channel: one message byte per beat (byte_present), last_byte closes the
// message; byte_present=0 with last_byte=1 ends it without adding a byte.
// digest channel: 16 beats per message, lane 0 first, each lane MSB first,
// digest_last on the sixteenth beat.
// Throughput: one msg beat per cycle unless a closing beat waits on a full staging
// register. Every beat passes the input register and at most one lane round per lane
// before the lane registers; a block run does not stall the msg channel.
// Digest path: a closing msg beat passes the input register and the digest staging
// register, then loads the output shifter; a zero block owed after a full final
// block is run in the digest staging register on its way to the output shifter.
// The digest drains at one beat per cycle while digest.ready is high, so messages
// shorter than 16 bytes are limited by the 16-beat drain of the output shifter.
// A digest stall holds the output shifter; message bytes keep flowing until a
// closing beat meets a full staging register, then msg.ready drops.
// Reset (rst, synchronous): lanes, partial block and position clear, all
// pipeline and output valids drop.

module lut_round_digest
  import lrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lrd_in_if.sink    msg,
  lrd_out_if.source digest
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_present;
  logic       s1_last;

  // running state
  lane_set_t             lanes;
  logic [BLOCK_BITS-1:0] blk_buf;
  logic [3:0]            pos;

  // digest staging
  logic      s2_valid;
  lane_set_t s2_lanes;
  logic      s2_extra;

  // output shifter
  logic                   dig_busy;
  logic [DIGEST_BITS-1:0] dig_shift;
  logic [3:0]             dig_cnt;

  logic                   dig_free;
  logic                   s2_take;
  logic                   s1_adv;
  logic                   wrap;
  logic [BLOCK_BITS-1:0]  buf_with;
  lane_set_t              round_out;
  lane_set_t              final_lanes;
  logic [DIGEST_BITS-1:0] dig_load;

  assign dig_free  = !dig_busy || (digest.ready && dig_cnt == 4'(DIGEST_BYTES - 1));
  assign s2_take   = !s2_valid || dig_free;
  assign s1_adv    = s1_valid && (!s1_last || s2_take);
  assign msg.ready = !s1_valid || s1_adv;
  assign wrap      = s1_present && pos == 4'(BLOCK_BYTES - 1);

  always_comb begin
    buf_with = blk_buf;
    if (s1_present) begin
      buf_with[{pos, 3'b000} +: 8] = s1_data;
    end
  end

  always_comb begin
    for (int j = 0; j < LANE_COUNT; j++) begin
      round_out[j]   = lane_round(lanes[j], buf_with[j*LANE_BITS +: LANE_BITS]);
      final_lanes[j] = s2_extra ? lane_round(s2_lanes[j], '0) : s2_lanes[j];
      dig_load[(LANE_COUNT-1-j)*LANE_BITS +: LANE_BITS] = final_lanes[j];
    end
  end

  assign digest.valid       = dig_busy;
  assign digest.digest_byte = dig_shift[DIGEST_BITS-1 -: 8];
  assign digest.digest_last = dig_cnt == 4'(DIGEST_BYTES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      lanes    <= '0;
      blk_buf  <= '0;
      pos      <= '0;
      s2_valid <= 1'b0;
      dig_busy <= 1'b0;
      dig_cnt  <= '0;
    end else begin
      if (msg.ready) begin
        s1_valid <= msg.valid;
      end

      if (s1_adv) begin
        if (s1_last) begin
          lanes   <= '0;
          blk_buf <= '0;
          pos     <= '0;
        end else if (wrap) begin
          lanes   <= round_out;
          blk_buf <= '0;
          pos     <= '0;
        end else if (s1_present) begin
          blk_buf <= buf_with;
          pos     <= pos + 4'd1;
        end
      end

      if (s2_take) begin
        s2_valid <= s1_adv && s1_last;
      end

      if (s2_valid && dig_free) begin
        dig_busy <= 1'b1;
        dig_cnt  <= '0;
      end else if (dig_busy && digest.ready) begin
        dig_cnt <= dig_cnt + 4'd1;
        if (dig_cnt == 4'(DIGEST_BYTES - 1)) begin
          dig_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      s1_data    <= msg.data_byte;
      s1_present <= msg.byte_present;
      s1_last    <= msg.last_byte;
    end
    // hold the finished lanes, with a zero block still owed on a full final block
    if (s1_adv && s1_last && s2_take) begin
      s2_lanes <= round_out;
      s2_extra <= wrap;
    end
    if (s2_valid && dig_free) begin
      dig_shift <= dig_load;
    end else if (dig_busy && digest.ready) begin
      dig_shift <= dig_shift << 8;
    end
  end

endmodule

>>> hdl/lrd_checker.sv
`timescale 1ns / 1ps

module lrd_checker (
  input logic       clk,
  input logic       rst,
  input logic       msg_valid,
  input logic       msg_ready,
  input logic       msg_last,
  input logic       dig_valid,
  input logic       dig_ready,
  input logic [7:0] dig_byte,
  input logic       dig_last
);

  logic [3:0] beat_cnt;
  logic [1:0] pend;
  logic       msg_end;
  logic       dig_end;

  assign msg_end = msg_valid && msg_ready && msg_last;
  assign dig_end = dig_valid && dig_ready && dig_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_cnt <= '0;
      pend     <= '0;
    end else begin
      if (dig_valid && dig_ready) begin
        beat_cnt <= beat_cnt + 4'd1;
      end
      pend <= pend + 2'(msg_end) - 2'(dig_end);
    end
  end

  // reset drops the digest channel
  a_reset_idle: assert property (@(posedge clk) rst |=> !dig_valid)
    else $error("digest valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_ready |=> dig_valid && $stable(dig_byte) && $stable(dig_last))
    else $error("stalled digest beat changed");

  // a digest streams without gaps until its last beat
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_ready && !dig_last |=> dig_valid)
    else $error("gap inside digest");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> dig_last == (beat_cnt == 4'd15))
    else $error("digest_last on wrong beat");

  a_owed: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> pend != 2'd0)
    else $error("digest without a closed message");

endmodule

bind lut_round_digest lrd_checker u_lrd_checker (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg.valid),
  .msg_ready (msg.ready),
  .msg_last  (msg.last_byte),
  .dig_valid (digest.valid),
  .dig_ready (digest.ready),
  .dig_byte  (digest.digest_byte),
  .dig_last  (digest.digest_last)
);
